// ===== src/fdcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fdcs_pkg
// Shared types and constants for the flip-dot change scanner.
// ----------------------------------------------------------------------------
package fdcs_pkg;

    localparam int unsigned DEF_PANEL_WIDTH  = 112;
    localparam int unsigned DEF_PANEL_HEIGHT = 16;

    localparam int unsigned COL_W   = 7;
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = COL_W + ROW_W;

    localparam logic [LEN_W-1:0] GOOD_LEN = LEN_W'(2);

    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_TICK   = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_FLIP   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_BAD_LEN   = 2'd1,
        ST_BAD_FRAME = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    // One memory entry: shown state and pending flip
    typedef struct packed {
        logic shown;
        logic flip;
    } t_dot;

endpackage

// ===== src/flip_dot_change_scanner.sv =====
// ----------------------------------------------------------------------------
// flip_dot_change_scanner
// Per-dot shown/pending store for a flip-dot panel with a row-major scanner.
// ----------------------------------------------------------------------------
// The accepting edge issues the read of the one dot entry a word touches,
// and the next edge writes the entry back and loads the result registers,
// so the result strobe is high in the cycle after that. busy is high for
// one cycle after each accepted word, so a new word is not accepted before
// the last one is through (the entry is read, modified and written back
// with no forwarding). After reset busy stays high while every entry is set
// to shown and pending. The receiver cannot hold results off: each result is
// on the o_ ports for one cycle with o_strobe.
module flip_dot_change_scanner #(
    parameter int unsigned PANEL_WIDTH  = fdcs_pkg::DEF_PANEL_WIDTH,
    parameter int unsigned PANEL_HEIGHT = fdcs_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cmd,
    input  logic [fdcs_pkg::LEN_W-1:0]    i_byte_count,
    input  logic [fdcs_pkg::BYTE_W-1:0]   i_first_byte,
    input  logic [fdcs_pkg::BYTE_W-1:0]   i_second_byte,
    output logic                          o_strobe,
    output logic                          o_kind,
    output logic [1:0]                    o_status,
    output logic [fdcs_pkg::BYTE_W-1:0]   o_command_first,
    output logic [fdcs_pkg::BYTE_W-1:0]   o_command_second
);
    import fdcs_pkg::*;

    localparam int unsigned DOT_COUNT = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int unsigned ADDR_W    = (DOT_COUNT > 1) ? $clog2(DOT_COUNT) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DOT_COUNT - 1);
    localparam logic [COL_W:0]    WIDTH_C   = (COL_W + 1)'(PANEL_WIDTH);
    localparam logic [ROW_W:0]    HEIGHT_C  = (ROW_W + 1)'(PANEL_HEIGHT);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(PANEL_WIDTH - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(PANEL_HEIGHT - 1);

    t_dot dot_mem [DOT_COUNT];

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ROW_W-1:0]    r_scan_row, n_scan_row;
    logic [COL_W-1:0]    r_scan_col, n_scan_col;

    logic                r_cmd;
    logic [LEN_W-1:0]    r_len;
    logic [BYTE_W-1:0]   r_b0;
    logic [BYTE_W-1:0]   r_b1;
    logic [ADDR_W-1:0]   r_addr;
    t_dot                r_rd_data;

    logic                r_strobe, n_strobe;
    logic                r_kind, n_kind;
    logic [1:0]          r_status, n_status;
    logic [BYTE_W-1:0]   r_first, n_first;
    logic [BYTE_W-1:0]   r_second, n_second;

    logic                accept;
    logic [COL_W-1:0]    in_col;
    logic [ROW_W-1:0]    in_row;
    logic [COL_W-1:0]    sel_col;
    logic [ROW_W-1:0]    sel_row;
    logic                sel_in_range;
    logic [IDX_W-1:0]    sel_idx;
    logic [ADDR_W-1:0]   rd_addr;

    logic [COL_W-1:0]    pk_col;
    logic [ROW_W-1:0]    pk_row;
    logic                pk_in_range;
    logic                scan_in_range;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    t_dot                wr_data;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Address of the entry this word touches
    assign in_col = i_first_byte[COL_W-1:0];
    assign in_row = i_second_byte[ROW_W-1:0];
    always_comb begin
        if (t_cmd'(i_cmd) == CMD_TICK) begin
            sel_col = r_scan_col;
            sel_row = r_scan_row;
        end else begin
            sel_col = in_col;
            sel_row = in_row;
        end
        sel_in_range = ({1'b0, sel_col} < WIDTH_C) && ({1'b0, sel_row} < HEIGHT_C);
        sel_idx      = IDX_W'(sel_col) + IDX_W'(sel_row) * IDX_W'(PANEL_WIDTH);
        rd_addr      = sel_in_range ? sel_idx[ADDR_W-1:0] : '0;
    end

    // Memory: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            dot_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= dot_mem[rd_addr];
    end

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_len  <= i_byte_count;
            r_b0   <= i_first_byte;
            r_b1   <= i_second_byte;
            r_addr <= rd_addr;
        end
    end

    assign pk_col        = r_b0[COL_W-1:0];
    assign pk_row        = r_b1[ROW_W-1:0];
    assign pk_in_range   = ({1'b0, pk_col} < WIDTH_C) && ({1'b0, pk_row} < HEIGHT_C);
    assign scan_in_range = ({1'b0, r_scan_col} < WIDTH_C)
                        && ({1'b0, r_scan_row} < HEIGHT_C);

    always_comb begin
        n_state    = r_state;
        n_scan_row = r_scan_row;
        n_scan_col = r_scan_col;
        n_strobe   = 1'b0;
        n_kind     = KIND_STATUS;
        n_status   = ST_ACCEPTED;
        n_first    = '0;
        n_second   = '0;
        wr_en      = 1'b0;
        wr_addr    = r_addr;
        wr_data    = r_rd_data;

        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '{shown: 1'b1, flip: 1'b1};
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (t_cmd'(r_cmd) == CMD_PACKET) begin
                    n_strobe = 1'b1;
                    if (r_len != GOOD_LEN) begin
                        n_status = ST_BAD_LEN;
                    end else if (!r_b0[BYTE_W-1] || r_b1[BYTE_W-1]) begin
                        n_status = ST_BAD_FRAME;
                    end else if (!pk_in_range) begin
                        n_status = ST_BAD_POS;
                    end else begin
                        // a request equal to the shown state drops the flip
                        wr_en        = 1'b1;
                        wr_data.flip = r_b1[ROW_W] ^ r_rd_data.shown;
                    end
                end else if (!scan_in_range) begin
                    n_scan_row = '0;
                    n_scan_col = '0;
                end else begin
                    if (r_rd_data.flip) begin
                        wr_en    = 1'b1;
                        wr_data  = '{shown: !r_rd_data.shown, flip: 1'b0};
                        n_strobe = 1'b1;
                        n_kind   = KIND_FLIP;
                        n_first  = {1'b1, LAST_COL - r_scan_col};
                        n_second = {{(BYTE_W - ROW_W - 1){1'b0}}, !r_rd_data.shown,
                                    r_scan_row};
                    end
                    // advance in row-major order
                    if (r_scan_col >= LAST_COL) begin
                        n_scan_col = '0;
                        n_scan_row = (r_scan_row >= LAST_ROW) ? '0 : r_scan_row + 1'b1;
                    end else begin
                        n_scan_col = r_scan_col + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_scan_row <= '0;
            r_scan_col <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_scan_row <= n_scan_row;
            r_scan_col <= n_scan_col;
            r_strobe   <= n_strobe;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_first  <= n_first;
        r_second <= n_second;
    end

    assign o_strobe         = r_strobe;
    assign o_kind           = r_kind;
    assign o_status         = r_status;
    assign o_command_first  = r_first;
    assign o_command_second = r_second;

endmodule
